// File: hdl/dai_pkg.sv
package dai_pkg;

  localparam int MAX_CHANNELS_DEF = 256;
  localparam int Z_LIMIT          = 2048;
  localparam int ROM_DEPTH        = Z_LIMIT + 1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic CFG_NO_ROOT = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  localparam logic [15:0] EPSILON_RST = 16'd1;

  // exp(-1/256) in Q0.62 from its series, each term floored
  localparam logic [63:0] EXP_ONE  = 64'd1 << 62;
  localparam logic [63:0] EXP_T1   = EXP_ONE / 64'd256;
  localparam logic [63:0] EXP_T2   = EXP_T1 / 64'd512;
  localparam logic [63:0] EXP_T3   = EXP_T2 / 64'd768;
  localparam logic [63:0] EXP_T4   = EXP_T3 / 64'd1024;
  localparam logic [63:0] EXP_T5   = EXP_T4 / 64'd1280;
  localparam logic [63:0] EXP_T6   = EXP_T5 / 64'd1536;
  localparam logic [63:0] EXP_T7   = EXP_T6 / 64'd1792;
  localparam logic [63:0] EXP_T8   = EXP_T7 / 64'd2048;
  localparam logic [63:0] EXP_T9   = EXP_T8 / 64'd2304;
  localparam logic [63:0] EXP_T10  = EXP_T9 / 64'd2560;
  localparam logic [63:0] EXP_T11  = EXP_T10 / 64'd2816;
  localparam logic [63:0] EXP_T12  = EXP_T11 / 64'd3072;
  localparam logic [63:0] EXP_STEP = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                                     + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
                                     - EXP_T11 + EXP_T12;

  typedef logic [15:0] sig_rom_t [0:ROM_DEPTH-1];

  // round(65536*sigmoid(k/256)) for k >= 0; exp(-k/256) stepped in Q0.62
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    logic [63:0] one;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] q;
    logic [127:0] prod;
    one  = EXP_ONE;
    step = EXP_STEP;
    e    = one;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      d = one + e;
      r = one;
      q = 64'd0;
      if (r >= d) begin
        q = 64'd1;
        r = r - d;
      end
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          q = q | 64'd1;
          r = r - d;
        end
      end
      if (r >= d - r) q = q + 64'd1;
      if (q > 64'd65535) q = 64'd65535;
      rom[k] = q[15:0];
      prod = {64'd0, e} * {64'd0, step};
      e = prod[125:62];
    end
    return rom;
  endfunction

endpackage

// File: hdl/dai_in_if.sv
interface dai_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         channel;
  logic signed [15:0] sample;
  logic signed [15:0] mean_value;
  logic [15:0]        variance;
  logic signed [15:0] scale_gamma;
  logic               last_in;

  modport source (output valid, cmd, channel, sample, mean_value, variance, scale_gamma,
                  last_in, input ready);
  modport sink (input valid, cmd, channel, sample, mean_value, variance, scale_gamma,
                last_in, output ready);
endinterface

// File: hdl/dai_out_if.sv
interface dai_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] activation;
  logic               saturated;
  logic               last_out;

  modport source (output valid, activation, saturated, last_out, input ready);
  modport sink (input valid, activation, saturated, last_out, output ready);
endinterface

// File: hdl/dice_adaptive_activation_top.sv
// Dice activation, Q8.8. Takes one beat per clock unless the output stalls. A load
// beat stores a channel's mean, variance and gamma and gives no result; a sample
// beat gives one result through 1 table read, 1 setup, 13 square-root stages, 1 setup
// and 11 quotient stages of the divider, 1 index, 1 sigmoid ROM read, 2 multiplies and
// 1 output register. The whole pipeline moves together; it halts only while a
// result sits in the output register and the sink is not ready. Configuration
// (no_root_mode, epsilon) must be written while no beats are in flight.
module dice_adaptive_activation_top #(
  parameter int MAX_CHANNELS = dai_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dai_in_if.sink      in_bus,
  dai_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SQ_N    = 13;  // root bits of a 26-bit radicand
  localparam int RAD_W   = 2 * SQ_N;
  localparam int REM_W   = 16;
  localparam int DV_N    = 11;  // quotient bits below the clamp
  localparam dai_pkg::sig_rom_t SIG_ROM = dai_pkg::build_sig_rom();

  typedef struct packed {
    logic               valid;
    logic               last;
    logic signed [15:0] x;
    logic signed [15:0] gamma;
  } ctx_t;

  // global advance: everything moves unless the output is stuck
  logic adv;
  assign adv          = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = adv;

  // config
  logic        no_root_r;
  logic [15:0] eps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_root_r <= 1'b0;
      eps_r     <= dai_pkg::EPSILON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dai_pkg::CFG_NO_ROOT: no_root_r <= cfg_data[0];
        dai_pkg::CFG_EPSILON: eps_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: parameter table
  logic [47:0] param_mem [0:MAX_CHANNELS-1];
  logic [47:0] rd_r;
  logic        in_range;
  logic        acc;
  logic [AW-1:0] addr;
  ctx_t        s1_r;
  logic        s1_oob_r;

  assign in_range = 32'(in_bus.channel) < MAX_CHANNELS;
  assign acc      = in_bus.valid && adv;
  assign addr     = AW'(in_bus.channel);

  always_ff @(posedge clk) begin
    if (acc && in_bus.cmd == dai_pkg::CMD_LOAD && in_range) begin
      param_mem[addr] <= {in_bus.mean_value, in_bus.variance, in_bus.scale_gamma};
    end
    if (adv && in_range) rd_r <= param_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= in_bus.valid && in_bus.cmd == dai_pkg::CMD_SAMPLE;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.last  <= in_bus.last_in;
      s1_r.x     <= in_bus.sample;
      s1_r.gamma <= '0;
      s1_oob_r   <= !in_range;
    end
  end

  // stage 2: setup of square root, numerator
  logic [47:0]        ent;
  logic signed [15:0] ent_mean;
  logic [15:0]        ent_var;
  logic [16:0]        var_eps;
  ctx_t               s2_ctx;
  assign ent      = s1_oob_r ? 48'd0 : rd_r;
  assign ent_mean = ent[47:32];
  assign ent_var  = ent[31:16];
  assign var_eps  = {1'b0, ent_var} + {1'b0, eps_r};
  always_comb begin
    s2_ctx       = s1_r;
    s2_ctx.gamma = ent[15:0];
  end

  // square-root pipeline, one root bit per stage
  ctx_t               sq_ctx_r  [0:SQ_N];
  logic [RAD_W-1:0]   sq_rad_r  [0:SQ_N];
  logic [REM_W-1:0]   sq_rem_r  [0:SQ_N];
  logic [SQ_N-1:0]    sq_root_r [0:SQ_N];
  logic signed [16:0] sq_n_r    [0:SQ_N];
  logic [15:0]        sq_var_r  [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctx_r[0].valid <= 1'b0;
    end else if (adv) begin
      sq_ctx_r[0].valid <= s2_ctx.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctx_r[0].last  <= s2_ctx.last;
      sq_ctx_r[0].x     <= s2_ctx.x;
      sq_ctx_r[0].gamma <= s2_ctx.gamma;
      sq_rad_r[0]       <= {1'b0, var_eps, 8'd0};
      sq_rem_r[0]       <= '0;
      sq_root_r[0]      <= '0;
      sq_n_r[0]         <= 17'(s1_r.x) - 17'(ent_mean);
      sq_var_r[0]       <= ent_var;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;
    assign rem_sh = {sq_rem_r[k][REM_W-3:0], sq_rad_r[k][RAD_W-1 -: 2]};
    assign trial  = REM_W'({sq_root_r[k], 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctx_r[k+1].valid <= 1'b0;
      end else if (adv) begin
        sq_ctx_r[k+1].valid <= sq_ctx_r[k].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx_r[k+1].last  <= sq_ctx_r[k].last;
        sq_ctx_r[k+1].x     <= sq_ctx_r[k].x;
        sq_ctx_r[k+1].gamma <= sq_ctx_r[k].gamma;
        sq_rad_r[k+1]       <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]       <= take ? rem_sh - trial : rem_sh;
        sq_root_r[k+1]      <= {sq_root_r[k][SQ_N-2:0], take};
        sq_n_r[k+1]         <= sq_n_r[k];
        sq_var_r[k+1]       <= sq_var_r[k];
      end
    end
  end

  // divider setup: |n|*256 against s, clamp detect
  logic [15:0] dv_s;
  logic [16:0] n_abs;
  logic [24:0] dv_a;
  assign dv_s  = no_root_r ? sq_var_r[SQ_N] : 16'(sq_root_r[SQ_N]);
  assign n_abs = sq_n_r[SQ_N][16] ? 17'(-sq_n_r[SQ_N]) : 17'(sq_n_r[SQ_N]);
  assign dv_a  = {n_abs, 8'd0};

  ctx_t        dv_ctx_r  [0:DV_N];
  logic [24:0] dv_rem_r  [0:DV_N];
  logic [DV_N-1:0] dv_q_r [0:DV_N];
  logic [15:0] dv_s_r    [0:DV_N];
  logic        dv_neg_r  [0:DV_N];
  logic        dv_nz_r   [0:DV_N];
  logic        dv_ovf_r  [0:DV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctx_r[0].valid <= 1'b0;
    end else if (adv) begin
      dv_ctx_r[0].valid <= sq_ctx_r[SQ_N].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx_r[0].last  <= sq_ctx_r[SQ_N].last;
      dv_ctx_r[0].x     <= sq_ctx_r[SQ_N].x;
      dv_ctx_r[0].gamma <= sq_ctx_r[SQ_N].gamma;
      dv_rem_r[0]       <= dv_a;
      dv_q_r[0]         <= '0;
      dv_s_r[0]         <= dv_s;
      dv_neg_r[0]       <= sq_n_r[SQ_N][16];
      dv_nz_r[0]        <= sq_n_r[SQ_N] != 17'sd0;
      dv_ovf_r[0]       <= {2'b0, dv_a} >= ({11'd0, dv_s} << DV_N);
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    localparam int B = DV_N - 1 - k;
    logic [26:0] sh;
    logic        take;
    assign sh   = {11'd0, dv_s_r[k]} << B;
    assign take = {2'b0, dv_rem_r[k]} >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctx_r[k+1].valid <= 1'b0;
      end else if (adv) begin
        dv_ctx_r[k+1].valid <= dv_ctx_r[k].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctx_r[k+1].last  <= dv_ctx_r[k].last;
        dv_ctx_r[k+1].x     <= dv_ctx_r[k].x;
        dv_ctx_r[k+1].gamma <= dv_ctx_r[k].gamma;
        dv_rem_r[k+1]       <= take ? dv_rem_r[k] - sh[24:0] : dv_rem_r[k];
        dv_q_r[k+1]         <= dv_q_r[k] | (take ? DV_N'(1) << B : '0);
        dv_s_r[k+1]         <= dv_s_r[k];
        dv_neg_r[k+1]       <= dv_neg_r[k];
        dv_nz_r[k+1]        <= dv_nz_r[k];
        dv_ovf_r[k+1]       <= dv_ovf_r[k];
      end
    end
  end

  // z to ROM index: |z| and sign
  logic [11:0] idx;
  logic        zneg;
  logic [11:0] q_up;
  assign q_up = {1'b0, dv_q_r[DV_N]} + {11'd0, dv_rem_r[DV_N] != 25'd0};
  always_comb begin
    zneg = dv_neg_r[DV_N] && dv_nz_r[DV_N];
    priority if (dv_s_r[DV_N] == 16'd0 || dv_ovf_r[DV_N]) begin
      // zero divisor or overflow: clamp by sign, or zero when n is zero
      if (!dv_nz_r[DV_N]) idx = 12'd0;
      else if (dv_neg_r[DV_N]) idx = 12'd2048;
      else idx = 12'd2047;
    end else if (dv_neg_r[DV_N]) begin
      idx = q_up;
      zneg = q_up != 12'd0;
    end else begin
      idx  = {1'b0, dv_q_r[DV_N]};
      zneg = 1'b0;
    end
  end

  ctx_t        zi_ctx_r;
  logic [11:0] zi_idx_r;
  logic        zi_neg_r;
  ctx_t        rom_ctx_r;
  logic [15:0] rom_r;
  logic        rom_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zi_ctx_r.valid  <= 1'b0;
      rom_ctx_r.valid <= 1'b0;
    end else if (adv) begin
      zi_ctx_r.valid  <= dv_ctx_r[DV_N].valid;
      rom_ctx_r.valid <= zi_ctx_r.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zi_ctx_r.last   <= dv_ctx_r[DV_N].last;
      zi_ctx_r.x      <= dv_ctx_r[DV_N].x;
      zi_ctx_r.gamma  <= dv_ctx_r[DV_N].gamma;
      zi_idx_r        <= idx;
      zi_neg_r        <= zneg;
      rom_ctx_r.last  <= zi_ctx_r.last;
      rom_ctx_r.x     <= zi_ctx_r.x;
      rom_ctx_r.gamma <= zi_ctx_r.gamma;
      rom_r           <= SIG_ROM[zi_idx_r];
      rom_neg_r       <= zi_neg_r;
    end
  end

  // blend: w = (65536-p)*gamma + 256*p, then w*x
  logic [16:0]        p;
  logic [16:0]        p_inv;
  logic signed [34:0] w;
  assign p     = rom_neg_r ? 17'd65536 - {1'b0, rom_r} : {1'b0, rom_r};
  assign p_inv = 17'd65536 - p;
  assign w     = 35'(signed'({1'b0, p_inv}) * rom_ctx_r.gamma) + 35'({p, 8'd0});

  ctx_t               m1_ctx_r;
  logic signed [34:0] m1_w_r;
  logic               m2_valid_r;
  logic               m2_last_r;
  logic signed [50:0] m2_num_r;
  logic signed [26:0] y;
  logic               y_hi;
  logic               y_lo;

  assign y    = 27'(m2_num_r >>> 24);
  assign y_hi = y > 27'sd32767;
  assign y_lo = y < -27'sd32768;

  logic               out_valid_r;
  logic signed [15:0] out_act_r;
  logic               out_sat_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctx_r.valid <= 1'b0;
      m2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (adv) begin
      m1_ctx_r.valid <= rom_ctx_r.valid;
      m2_valid_r     <= m1_ctx_r.valid;
      out_valid_r    <= m2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ctx_r.last  <= rom_ctx_r.last;
      m1_ctx_r.x     <= rom_ctx_r.x;
      m1_ctx_r.gamma <= rom_ctx_r.gamma;
      m1_w_r         <= w;
      m2_last_r      <= m1_ctx_r.last;
      m2_num_r       <= 51'(m1_w_r * m1_ctx_r.x);
      out_last_r     <= m2_last_r;
      out_sat_r      <= y_hi || y_lo;
      if (y_hi)      out_act_r <= 16'sh7fff;
      else if (y_lo) out_act_r <= -16'sh8000;
      else           out_act_r <= y[15:0];
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.activation = out_act_r;
  assign out_bus.saturated  = out_sat_r;
  assign out_bus.last_out   = out_last_r;

endmodule

// File: hdl/dai_checker.sv
module dai_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] activation,
  input logic               saturated
);

  // pipeline halts only behind a stuck result
  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input not ready without output stall");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // saturation flag means a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && saturated) |-> (activation == 16'sh7fff || activation == -16'sh8000))
    else $error("saturated flag without bound value");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(activation)))
    else $error("stalled result changed");

endmodule

bind dice_adaptive_activation_top dai_checker u_dai_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .activation (out_bus.activation),
  .saturated  (out_bus.saturated)
);

// File: bench/tb_dice_adaptive_activation_top.sv
`timescale 1ns / 100ps

module tb_dice_adaptive_activation_top;

  localparam int  PIPE_LAT    = 32;
  localparam int  SETTLE      = PIPE_LAT + 10;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  RAND_PHASES = 6;
  localparam int  PER_PHASE   = 100;

  // one beat of the result channel
  typedef struct packed {
    logic signed [15:0] activation;
    logic               saturated;
    logic               last_out;
  } dice_result_t;

  // per-channel parameters as the block should hold them
  typedef struct packed {
    logic signed [15:0] mean;
    logic [15:0]        var_q;
    logic signed [15:0] gamma;
  } chan_param_t;

  // directed row: either a register write or one input beat
  typedef struct {
    bit                 is_reg;
    logic               reg_idx;
    logic [15:0]        reg_val;
    logic               cmd;
    logic [7:0]         ch;
    logic signed [15:0] x;
    logic signed [15:0] mean;
    logic [15:0]        var_q;
    logic signed [15:0] gamma;
    logic               last;
    bit                 typed;
    logic signed [15:0] y;
    logic               sat;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  dai_in_if  in_bus ();
  dai_out_if out_bus ();

  dice_adaptive_activation_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow state
  logic [15:0]  sigmoid_tab [0:dai_pkg::Z_LIMIT];
  chan_param_t  chan_tab [0:255];
  bit           chan_loaded [0:255];
  logic         root_off;
  logic [15:0]  eps_q;

  dice_result_t pending_results [$];
  int mismatches;
  int results_seen;
  int samples_sent;
  int loads_sent;
  int sat_seen;
  int cycles;
  bit burst_mode;

  // sigmoid table, exp(-k/256) advanced in Q0.62 with a floored product each step
  task automatic build_sigmoid_tab();
    logic [63:0]  unit;
    logic [63:0]  term;
    logic [63:0]  decay;
    logic [63:0]  ex;
    logic [127:0] wide;
    logic [127:0] quo;
    logic [127:0] rem;
    unit  = 64'd1 << 62;
    term  = unit;
    decay = unit;
    ex    = unit;
    for (int n = 1; n <= 12; n++) begin
      term = term / (64'd256 * 64'(n));
      decay = (n & 1) ? decay - term : decay + term;
    end
    for (int k = 0; k <= dai_pkg::Z_LIMIT; k++) begin
      quo = (128'd1 << 78) / {64'd0, unit + ex};
      rem = (128'd1 << 78) % {64'd0, unit + ex};
      if (2 * rem >= {64'd0, unit + ex}) quo = quo + 1;
      if (quo > 128'd65535) quo = 128'd65535;
      sigmoid_tab[k] = quo[15:0];
      wide = {64'd0, ex} * {64'd0, decay};
      ex = wide[125:62];
    end
  endtask

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 13; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (longint'(trial) * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic dice_result_t dice_predict(logic [7:0] ch, logic signed [15:0] x,
                                                logic last);
    dice_result_t res;
    chan_param_t  prm;
    int unsigned  div;
    longint       numer;
    longint       z;
    longint       blend;
    longint       y;
    longint       p;
    prm = chan_tab[ch];
    div = root_off ? int'(prm.var_q) : int_sqrt((int'(prm.var_q) + int'(eps_q)) * 256);
    numer = (longint'(x) - longint'(prm.mean)) * 256;
    if (div == 0) begin
      z = (numer > 0) ? dai_pkg::Z_LIMIT - 1 : (numer < 0 ? -dai_pkg::Z_LIMIT : 0);
    end else begin
      z = numer / longint'(div);
      if ((numer % longint'(div)) != 0 && numer < 0) z = z - 1;
    end
    if (z > dai_pkg::Z_LIMIT - 1) z = dai_pkg::Z_LIMIT - 1;
    if (z < -dai_pkg::Z_LIMIT) z = -dai_pkg::Z_LIMIT;
    p = (z >= 0) ? longint'(sigmoid_tab[z]) : 65536 - longint'(sigmoid_tab[-z]);
    blend = (65536 - p) * longint'(prm.gamma) * longint'(x) + 256 * p * longint'(x);
    y = blend >>> 24;
    res.saturated = 1'b0;
    if (y > 32767) begin
      y = 32767;
      res.saturated = 1'b1;
    end
    if (y < -32768) begin
      y = -32768;
      res.saturated = 1'b1;
    end
    res.activation = y[15:0];
    res.last_out = last;
    return res;
  endfunction

  // gap length: mostly none or short, now and then long; none at all in burst mode
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'(int'($urandom_range(0, 63)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dai_pkg::CFG_NO_ROOT) root_off = val[0];
    else eps_q = val;
    @(posedge clk);
  endtask

  // drive one beat, hold until taken, then update the shadow table or queue the result
  task automatic send_beat(logic cmd, logic [7:0] ch, logic signed [15:0] x,
                           logic signed [15:0] mean, logic [15:0] var_q,
                           logic signed [15:0] gamma, logic last,
                           bit typed, logic signed [15:0] y, logic sat);
    dice_result_t want;
    int gap;
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= cmd;
    in_bus.channel     <= ch;
    in_bus.sample      <= x;
    in_bus.mean_value  <= mean;
    in_bus.variance    <= var_q;
    in_bus.scale_gamma <= gamma;
    in_bus.last_in     <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (cmd == dai_pkg::CMD_LOAD) begin
      chan_tab[ch]    = '{mean: mean, var_q: var_q, gamma: gamma};
      chan_loaded[ch] = 1'b1;
      loads_sent++;
    end else begin
      if (typed) want = '{activation: y, saturated: sat, last_out: last};
      else want = dice_predict(ch, x, last);
      pending_results.push_back(want);
      samples_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random stall pattern plus checking against the oldest expectation.
  int stall_left;
  always @(posedge clk) begin
    dice_result_t got;
    dice_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{activation: out_bus.activation, saturated: out_bus.saturated,
              last_out: out_bus.last_out};
      results_seen++;
      if (got.saturated) sat_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat act=%0d sat=%0b last=%0b",
                   got.activation, got.saturated, got.last_out);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp act=%0d sat=%0b last=%0b got act=%0d sat=%0b last=%0b",
                     results_seen, want.activation, want.saturated, want.last_out,
                     got.activation, got.saturated, got.last_out);
        end
      end
    end
    // ready: long open stretches in burst mode, otherwise random short/long stalls
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed part: extremes, both commands, zero divisor in both modes, saturation.
  // With gamma = 1.0 the blend collapses to y = x for any sigmoid weight.
  dir_row_t dir_rows [] = '{
    '{0, 0, 0, dai_pkg::CMD_LOAD,   8'd0,   16'sd0,      16'sd0,      16'd256,   16'sd256,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_LOAD,   8'd255, 16'sd0,      -16'sd32768, 16'd65535, -16'sd32768,
      1, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_LOAD,   8'd1,   16'sd0,      16'sd0,      16'd0,     -16'sd32768,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_LOAD,   8'd170, 16'sd0,      16'sd32767,  16'd1,     16'sd32767,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_LOAD,   8'd85,  16'sd0,      16'sd100,    16'd3,     -16'sd256,
      1, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd0,   16'sd0,      16'sd0,      16'd0,     16'sd0,
      1, 1, 16'sd0,      0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd0,   16'sd32767,  16'sd0,      16'd0,     16'sd0,
      0, 1, 16'sd32767,  0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd0,   -16'sd32768, 16'sd0,      16'd0,     16'sd0,
      1, 1, -16'sd32768, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   -16'sd32768, 16'sd0,      16'd0,     16'sd0,
      0, 1, 16'sd32767,  1},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   16'sd32767,  16'sd0,      16'd0,     16'sd0,
      1, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd255, 16'sd32767,  16'sd0,      16'd0,     16'sd0,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd255, -16'sd32768, 16'sd0,      16'd0,     16'sd0,
      1, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd170, 16'sd0,      16'sd0,      16'd0,     16'sd0,
      0, 1, 16'sd0,      0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd170, -16'sd32768, 16'sd0,      16'd0,     16'sd0,
      1, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd85,  16'sd99,     16'sd0,      16'd0,     16'sd0,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd85,  16'sd101,    16'sd0,      16'd0,     16'sd0,
      1, 0, 0, 0},
    // no-root mode: channel 1 has variance zero, so the divisor is zero
    '{1, dai_pkg::CFG_NO_ROOT, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   16'sd0,      16'sd0,      16'd0,     16'sd0,
      1, 1, 16'sd0,      0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   16'sd5,      16'sd0,      16'd0,     16'sd0,
      0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   -16'sd5,     16'sd0,      16'd0,     16'sd0,
      1, 0, 0, 0},
    // root mode with epsilon zero: zero variance again gives a zero divisor
    '{1, dai_pkg::CFG_NO_ROOT, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, dai_pkg::CFG_EPSILON, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   -16'sd32768, 16'sd0,      16'd0,     16'sd0,
      0, 1, 16'sd32767,  1},
    '{0, 0, 0, dai_pkg::CMD_SAMPLE, 8'd1,   16'sd0,      16'sd0,      16'd0,     16'sd0,
      1, 1, 16'sd0,      0}
  };

  logic        phase_root [RAND_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
  logic [15:0] phase_eps  [RAND_PHASES] = '{16'd1, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd300};

  initial begin
    logic [7:0] ch;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dai_pkg::CFG_NO_ROOT;
    cfg_data = 16'd0;
    in_bus.valid = 1'b0;
    in_bus.cmd = dai_pkg::CMD_SAMPLE;
    in_bus.channel = 8'd0;
    in_bus.sample = 16'sd0;
    in_bus.mean_value = 16'sd0;
    in_bus.variance = 16'd0;
    in_bus.scale_gamma = 16'sd0;
    in_bus.last_in = 1'b0;
    out_bus.ready = 1'b0;
    stall_left = 0;
    mismatches = 0;
    results_seen = 0;
    samples_sent = 0;
    loads_sent = 0;
    sat_seen = 0;
    cycles = 0;
    burst_mode = 1'b0;
    root_off = 1'b0;
    eps_q = dai_pkg::EPSILON_RST;
    foreach (chan_loaded[i]) chan_loaded[i] = 1'b0;
    build_sigmoid_tab();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        in_bus.valid <= 1'b0;
        wait_drained();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_beat(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].x, dir_rows[i].mean,
                  dir_rows[i].var_q, dir_rows[i].gamma, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].y, dir_rows[i].sat);
      end
    end

    // Random part: one register setting per phase; samples only hit loaded channels,
    // an unloaded pick turns into a load of that channel.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_bus.valid <= 1'b0;
      wait_drained();
      write_reg(dai_pkg::CFG_NO_ROOT, {15'd0, phase_root[ph]});
      write_reg(dai_pkg::CFG_EPSILON, phase_eps[ph]);
      for (int k = 0; k < PER_PHASE; k++) begin
        if (k % 25 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        ch = 8'($urandom);
        if (!chan_loaded[ch] || $urandom_range(0, 9) == 0) begin
          send_beat(dai_pkg::CMD_LOAD, ch, pick_word(), pick_word(),
                    ($urandom_range(0, 2) == 0) ? pick_word() : 16'($urandom_range(0, 2048)),
                    ($urandom_range(0, 1) == 0) ? pick_word() : 16'($urandom_range(0, 512)),
                    1'($urandom), 0, 16'sd0, 1'b0);
        end else begin
          send_beat(dai_pkg::CMD_SAMPLE, ch, pick_word(), pick_word(), pick_word(),
                    pick_word(), 1'($urandom), 0, 16'sd0, 1'b0);
        end
      end
    end
    burst_mode = 1'b0;
    in_bus.valid <= 1'b0;
    wait_drained();

    $display("Covered %0d sample beats and %0d load beats over %0d register settings.",
             samples_sent, loads_sent, RAND_PHASES + 3);
    $display("Checked %0d results (%0d saturated), %0d mismatches.",
             results_seen, sat_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
